// ----- hdl/psl_pkg.sv -----
// Shared types, widths and constants for the Phong specular lobe pipeline.
// Used by psl_log, psl_exp and phong_specular_lobe; depends on nothing.
`default_nettype none

package psl_pkg;

  // Fixed-point format of the vector components and colours
  localparam int FB      = 14;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 15;
  localparam int GAIN_W  = 16;
  localparam int COL_W   = 15;
  localparam int SHIN_W  = 16;
  localparam int CFG_I_W = 3;
  localparam int CFG_D_W = 16;

  // Dot product and reflection widths
  localparam int PROD_W = 2 * IN_W;
  localparam int NL_W   = PROD_W + 2;
  localparam int D_W    = NL_W - FB;
  localparam int R_W    = IN_W + D_W + 2;
  localparam int RF_W   = R_W - FB;
  localparam int RVP_W  = RF_W + IN_W;
  localparam int RV_W   = RVP_W + 2;
  localparam int X_W    = 2 * FB + 1;

  // Log2 unit
  localparam int P_W       = $clog2(X_W);
  localparam int M_W       = 31;
  localparam int NORM_W    = (X_W > M_W) ? X_W : M_W;
  localparam int LOG_STEPS = 16;
  localparam int G_W       = P_W + 16;

  // Exp2 unit
  localparam int A_W    = G_W + SHIN_W;
  localparam int U_W    = 24;
  localparam int Z_W    = 32;
  localparam int T_W    = 33;
  localparam int SH_W   = 6;
  localparam int HORNER = 8;
  localparam int GC_W   = GAIN_W + COL_W;
  localparam int CH_W   = 16;

  localparam logic [Z_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [T_W-1:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [X_W-1:0] ONE_X   = X_W'(1) << (2 * FB);
  localparam logic [CH_W-1:0] CH_MAX = 16'd32767;

  // floor(2^32 / k) for k = 1 .. 8, indexed by k - 1
  localparam logic [T_W-1:0] RECIP [HORNER] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912
  };

  typedef enum logic [CFG_I_W-1:0] {
    CFG_GAIN  = 3'd0,
    CFG_RED   = 3'd1,
    CFG_GREEN = 3'd2,
    CFG_BLUE  = 3'd3,
    CFG_SHIN  = 3'd4
  } psl_cfg_idx_t;

  typedef struct packed {
    logic signed [IN_W-1:0] normal_x;
    logic signed [IN_W-1:0] normal_y;
    logic signed [IN_W-1:0] normal_z;
    logic signed [IN_W-1:0] light_x;
    logic signed [IN_W-1:0] light_y;
    logic signed [IN_W-1:0] light_z;
    logic signed [IN_W-1:0] view_x;
    logic signed [IN_W-1:0] view_y;
    logic signed [IN_W-1:0] view_z;
  } psl_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_red;
    logic [OUT_W-1:0] out_green;
    logic [OUT_W-1:0] out_blue;
    logic             lobe_hit;
  } psl_out_t;

  // Control that travels beside each beat
  typedef struct packed {
    logic valid;
    logic hit;
  } psl_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/psl_log.sv -----
// Pipelined log2 of the clamped dot product: normalize, sixteen square steps.
// Depends on psl_pkg. One beat accepted per cycle.
`default_nettype none

module psl_log (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire psl_pkg::psl_ctl_t       ctl_in,
  input  wire logic [psl_pkg::X_W-1:0] x_in,
  output psl_pkg::psl_ctl_t            ctl_out,
  output logic [psl_pkg::G_W-1:0]      g_out
);
  import psl_pkg::*;

  logic [P_W-1:0]    p_c;
  logic [P_W:0]      sh_c;
  logic [NORM_W-1:0] norm_c;

  psl_ctl_t          c_q [LOG_STEPS+1];
  logic [M_W-1:0]    m_q [LOG_STEPS+1];
  logic [15:0]       f_q [LOG_STEPS+1];
  logic [P_W-1:0]    p_q [LOG_STEPS+1];

  logic [P_W-1:0]    diff_c;

  // Position of the top set bit, then shift it to the top of the mantissa.
  always_comb begin
    p_c = '0;
    for (int b = 0; b < X_W; b++) begin
      if (x_in[b]) begin
        p_c = P_W'(b);
      end
    end
    sh_c   = (P_W+1)'(NORM_W - 1) - {1'b0, p_c};
    norm_c = NORM_W'(x_in) << sh_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_q[0] <= '0;
    end else begin
      c_q[0] <= ctl_in;
    end
    m_q[0] <= norm_c[NORM_W-1 -: M_W];
    f_q[0] <= '0;
    p_q[0] <= p_c;
  end

  // One square-and-compare step per stage gives one fraction bit.
  for (genvar s = 0; s < LOG_STEPS; s++) begin : g_sq
    logic [2*M_W-1:0] sq_c;
    logic [M_W:0]     mm_c;

    always_comb begin
      sq_c = m_q[s] * m_q[s];
      mm_c = sq_c[2*M_W-1:M_W-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_q[s+1] <= '0;
      end else begin
        c_q[s+1] <= c_q[s];
      end
      m_q[s+1] <= mm_c[M_W] ? mm_c[M_W:1] : mm_c[M_W-1:0];
      f_q[s+1] <= f_q[s] | (16'(mm_c[M_W]) << (LOG_STEPS - 1 - s));
      p_q[s+1] <= p_q[s];
    end
  end

  // Magnitude of the logarithm in Q.16.
  always_comb begin
    diff_c = P_W'(2 * FB) - p_q[LOG_STEPS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= c_q[LOG_STEPS];
    end
    g_out <= {diff_c, 16'd0} - {{P_W{1'b0}}, f_q[LOG_STEPS]};
  end

  // A full-scale input has its top bit at the clamp position and a zero log.
  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    c_q[0].valid |-> m_q[0][M_W-1])
    else $error("normalized mantissa lacks its leading one");

  a_sq_range: assert property (@(posedge clk) disable iff (rst)
    c_q[LOG_STEPS].valid |-> m_q[LOG_STEPS][M_W-1])
    else $error("squared mantissa fell out of range");

  a_ctl_delay: assert property (@(posedge clk) disable iff (rst)
    $past(c_q[LOG_STEPS].valid) |-> ctl_out.valid)
    else $error("beat lost in log pipeline");

endmodule

`default_nettype wire

// ----- hdl/psl_exp.sv -----
// Pipelined exp2 by scaled exponent, Horner series, gain and colour scaling.
// Depends on psl_pkg. One beat accepted per cycle.
`default_nettype none

module psl_exp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire psl_pkg::psl_ctl_t        ctl_in,
  input  wire logic [psl_pkg::G_W-1:0]  g_in,
  input  wire logic [psl_pkg::SHIN_W-1:0] shininess,
  input  wire logic [psl_pkg::GC_W-1:0] gc_red,
  input  wire logic [psl_pkg::GC_W-1:0] gc_green,
  input  wire logic [psl_pkg::GC_W-1:0] gc_blue,
  output logic                          done,
  output psl_pkg::psl_out_t             result
);
  import psl_pkg::*;

  // Scaled exponent
  psl_ctl_t         a_ctl;
  logic             a_zero;
  logic [SH_W-1:0]  a_int;
  logic [U_W-1:0]   a_frac;
  logic [A_W-1:0]   a_c;

  // Horner boundaries
  psl_ctl_t         h_ctl  [HORNER+1];
  logic             h_zero [HORNER+1];
  logic [SH_W-1:0]  h_int  [HORNER+1];
  logic [Z_W-1:0]   h_z    [HORNER+1];
  logic [T_W-1:0]   h_t    [HORNER+1];
  logic [U_W+Z_W-1:0] zp_c;

  // Power, then channel products
  psl_ctl_t         e_ctl;
  logic [T_W-1:0]   e_val;
  psl_ctl_t         c_ctl;
  logic [CH_W-1:0]  c_red;
  logic [CH_W-1:0]  c_green;
  logic [CH_W-1:0]  c_blue;
  logic [GC_W+T_W-1:0] pr_red;
  logic [GC_W+T_W-1:0] pr_green;
  logic [GC_W+T_W-1:0] pr_blue;

  always_comb begin
    a_c  = A_W'(g_in) * A_W'(shininess);
    zp_c = (U_W+Z_W)'(a_frac) * (U_W+Z_W)'(LN2_Q32);
  end

  // Split the exponent into whole shift and fraction; huge shifts give zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl    <= '0;
      h_ctl[0] <= '0;
    end else begin
      a_ctl    <= ctl_in;
      h_ctl[0] <= a_ctl;
    end
    a_zero    <= (a_c[A_W-1:U_W+SH_W] != '0);
    a_int     <= a_c[U_W+SH_W-1:U_W];
    a_frac    <= a_c[U_W-1:0];
    h_zero[0] <= a_zero;
    h_int[0]  <= a_int;
    h_z[0]    <= zp_c[U_W+Z_W-1:U_W];
    h_t[0]    <= ONE_Q32;
  end

  // Each term: multiply, reciprocal multiply, then one correction step.
  for (genvar h = 0; h < HORNER; h++) begin : g_hor
    localparam int K = HORNER - h;
    psl_ctl_t        ca, cb;
    logic            za, zb;
    logic [SH_W-1:0] ia, ib;
    logic [Z_W-1:0]  zza, zzb;
    logic [Z_W-1:0]  q, qb, qh;
    logic [Z_W+T_W-1:0] zt_c;
    logic [Z_W+T_W-1:0] qr_c;
    logic [Z_W-1:0]  rem_c;
    logic [Z_W-1:0]  quot_c;

    always_comb begin
      zt_c   = (Z_W+T_W)'(h_z[h]) * (Z_W+T_W)'(h_t[h]);
      qr_c   = (Z_W+T_W)'(q) * (Z_W+T_W)'(RECIP[K-1]);
      rem_c  = qb - qh * Z_W'(K);
      quot_c = (rem_c >= Z_W'(K)) ? qh + Z_W'(1) : qh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ca         <= '0;
        cb         <= '0;
        h_ctl[h+1] <= '0;
      end else begin
        ca         <= h_ctl[h];
        cb         <= ca;
        h_ctl[h+1] <= cb;
      end
      za  <= h_zero[h];
      ia  <= h_int[h];
      zza <= h_z[h];
      q   <= zt_c[Z_W+T_W-2:T_W-1];
      zb  <= za;
      ib  <= ia;
      zzb <= zza;
      qb  <= q;
      qh  <= qr_c[Z_W+T_W-2:T_W-1];
      h_zero[h+1] <= zb;
      h_int[h+1]  <= ib;
      h_z[h+1]    <= zzb;
      h_t[h+1]    <= ONE_Q32 - T_W'(quot_c);
    end
  end

  always_comb begin
    pr_red   = (GC_W+T_W)'(gc_red)   * (GC_W+T_W)'(e_val);
    pr_green = (GC_W+T_W)'(gc_green) * (GC_W+T_W)'(e_val);
    pr_blue  = (GC_W+T_W)'(gc_blue)  * (GC_W+T_W)'(e_val);
  end

  // Whole-part shift, channel products, saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctl <= '0;
      c_ctl <= '0;
      done  <= 1'b0;
    end else begin
      e_ctl <= h_ctl[HORNER];
      c_ctl <= e_ctl;
      done  <= c_ctl.valid;
    end
    e_val   <= h_zero[HORNER] ? '0 : (h_t[HORNER] >> h_int[HORNER]);
    c_red   <= pr_red[GC_W+T_W-1:48];
    c_green <= pr_green[GC_W+T_W-1:48];
    c_blue  <= pr_blue[GC_W+T_W-1:48];
    result.lobe_hit  <= c_ctl.hit;
    result.out_red   <= !c_ctl.hit ? '0 :
                        (c_red   > CH_MAX) ? OUT_W'(CH_MAX) : c_red[OUT_W-1:0];
    result.out_green <= !c_ctl.hit ? '0 :
                        (c_green > CH_MAX) ? OUT_W'(CH_MAX) : c_green[OUT_W-1:0];
    result.out_blue  <= !c_ctl.hit ? '0 :
                        (c_blue  > CH_MAX) ? OUT_W'(CH_MAX) : c_blue[OUT_W-1:0];
  end

  // A zero power can only give a black result, once through the channel product and output registers.
  a_zero_black: assert property (@(posedge clk) disable iff (rst)
    (e_ctl.valid && e_val == '0) |=> ##1
      (result.out_red == '0 && result.out_green == '0 && result.out_blue == '0))
    else $error("zero power produced color");

  a_power_max: assert property (@(posedge clk) disable iff (rst)
    e_ctl.valid |-> (e_val <= ONE_Q32))
    else $error("power above one");

  a_done_track: assert property (@(posedge clk) disable iff (rst)
    $past(c_ctl.valid) |-> done)
    else $error("beat lost at output");

endmodule

`default_nettype wire

// ----- hdl/phong_specular_lobe.sv -----
// Top level of the Phong specular lobe: registers, dot products, reflection.
// Depends on psl_pkg, psl_log and psl_exp.
//
//  channel  | signals                          | beat taken when
//  ---------+----------------------------------+---------------------------
//  input    | start, busy, item                | start && !busy
//  result   | done, result                     | done (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_index, | cfg_valid && cfg_ready
//           | cfg_data                         |
//
// One item is accepted every cycle while busy is low; its result comes out after
// the front stages, psl_log and psl_exp, with its done strobe. The depth is mostly
// set by the sixteen log2 square steps, one stage each, and the eight Horner
// terms of exp2, three stages each. busy is high during reset and for the
// cycle after it. Reset clears every valid bit and loads the register
// defaults. There is no stall: results must be taken as they appear.
`default_nettype none

module phong_specular_lobe (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire psl_pkg::psl_in_t               item,
  output logic                                done,
  output psl_pkg::psl_out_t                   result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [psl_pkg::CFG_I_W-1:0]    cfg_index,
  input  wire logic [psl_pkg::CFG_D_W-1:0]    cfg_data
);
  import psl_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0] specular_gain;
  logic [COL_W-1:0]  colour_red;
  logic [COL_W-1:0]  colour_green;
  logic [COL_W-1:0]  colour_blue;
  logic [SHIN_W-1:0] shininess;
  logic [GC_W-1:0]   gc_red;
  logic [GC_W-1:0]   gc_green;
  logic [GC_W-1:0]   gc_blue;

  // Front stages
  psl_ctl_t                s1_ctl, s2_ctl, s3_ctl, s4_ctl, s5_ctl;
  psl_in_t                 s1_item, s2_item;
  logic signed [IN_W-1:0]  s3_vx, s3_vy, s3_vz;
  logic signed [PROD_W-1:0] s1_px, s1_py, s1_pz;
  logic signed [D_W-1:0]   s2_d;
  logic signed [RF_W-1:0]  s3_rx, s3_ry, s3_rz;
  logic signed [RVP_W-1:0] s4_px, s4_py, s4_pz;
  logic [X_W-1:0]          s5_x;

  logic signed [NL_W-1:0]  nl_c;
  logic signed [R_W-1:0]   rx_c, ry_c, rz_c;
  logic signed [RV_W-1:0]  rv_c;
  psl_ctl_t                in_ctl;
  psl_ctl_t                lg_ctl;
  logic [G_W-1:0]          lg_g;

  assign cfg_ready = 1'b1;
  assign in_ctl    = '{valid: start && !busy, hit: 1'b0};

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      specular_gain <= '0;
      colour_red    <= COL_W'(16384);
      colour_green  <= COL_W'(16384);
      colour_blue   <= COL_W'(16384);
      shininess     <= SHIN_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN:  specular_gain <= cfg_data;
        CFG_RED:   colour_red    <= cfg_data[COL_W-1:0];
        CFG_GREEN: colour_green  <= cfg_data[COL_W-1:0];
        CFG_BLUE:  colour_blue   <= cfg_data[COL_W-1:0];
        CFG_SHIN:  shininess     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gain times colour follows the registers, settled long before use.
  always_ff @(posedge clk) begin
    gc_red   <= GC_W'(specular_gain) * GC_W'(colour_red);
    gc_green <= GC_W'(specular_gain) * GC_W'(colour_green);
    gc_blue  <= GC_W'(specular_gain) * GC_W'(colour_blue);
  end

  always_comb begin
    nl_c = NL_W'(s1_px) + NL_W'(s1_py) + NL_W'(s1_pz);
    rx_c = R_W'(s2_item.normal_x * s2_d) * R_W'(2)
           - (R_W'(s2_item.light_x) <<< FB);
    ry_c = R_W'(s2_item.normal_y * s2_d) * R_W'(2)
           - (R_W'(s2_item.light_y) <<< FB);
    rz_c = R_W'(s2_item.normal_z * s2_d) * R_W'(2)
           - (R_W'(s2_item.light_z) <<< FB);
    rv_c = RV_W'(s4_px) + RV_W'(s4_py) + RV_W'(s4_pz);
  end

  // Five stages: n.l products, floored sum, reflection, r.v products, clamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
      s4_ctl <= '0;
      s5_ctl <= '0;
    end else begin
      s1_ctl <= in_ctl;
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
      s4_ctl <= s3_ctl;
      s5_ctl <= '{valid: s4_ctl.valid, hit: rv_c > RV_W'(0)};
    end
    s1_item <= item;
    s1_px   <= item.normal_x * item.light_x;
    s1_py   <= item.normal_y * item.light_y;
    s1_pz   <= item.normal_z * item.light_z;
    s2_item <= s1_item;
    s2_d    <= D_W'(nl_c >>> FB);
    s3_vx   <= s2_item.view_x;
    s3_vy   <= s2_item.view_y;
    s3_vz   <= s2_item.view_z;
    s3_rx   <= RF_W'(rx_c >>> FB);
    s3_ry   <= RF_W'(ry_c >>> FB);
    s3_rz   <= RF_W'(rz_c >>> FB);
    s4_px   <= s3_rx * s3_vx;
    s4_py   <= s3_ry * s3_vy;
    s4_pz   <= s3_rz * s3_vz;
    if (rv_c <= RV_W'(0)) begin
      s5_x <= ONE_X;
    end else if (rv_c > RV_W'(ONE_X)) begin
      s5_x <= ONE_X;
    end else begin
      s5_x <= rv_c[X_W-1:0];
    end
  end

  psl_log u_log (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (s5_ctl),
    .x_in    (s5_x),
    .ctl_out (lg_ctl),
    .g_out   (lg_g)
  );

  psl_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (lg_ctl),
    .g_in      (lg_g),
    .shininess (shininess),
    .gc_red    (gc_red),
    .gc_green  (gc_green),
    .gc_blue   (gc_blue),
    .done      (done),
    .result    (result)
  );

  // A miss is always black.
  a_miss_black: assert property (@(posedge clk) disable iff (rst)
    (done && !result.lobe_hit) |->
      (result.out_red == '0 && result.out_green == '0 && result.out_blue == '0))
    else $error("miss produced color");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    s5_ctl.valid |-> (s5_x != '0 && s5_x <= ONE_X))
    else $error("clamped dot product out of range");

endmodule

`default_nettype wire
